// ===== design/indexed_insert_erase_list_defines.svh =====
// Assertion macros shared by the checkers of the indexed insert/erase list.
`ifndef INDEXED_INSERT_ERASE_LIST_DEFINES_SVH
`define INDEXED_INSERT_ERASE_LIST_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define IIEL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define IIEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iiel_pkg.sv =====
// Package with action codes, status codes and control types of the list.
`default_nettype none

package iiel_pkg;

  // Action codes.
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_ERASE  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // What a storage cell does in a given cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_op_e;

  // Outcome of one operation as seen by the count register and result stage.
  typedef struct packed {
    logic [1:0] status;
    logic       inc;
    logic       dec;
    logic       clr;
  } ctrl_res_t;

endpackage

`default_nettype wire

// ===== design/iiel_cell.sv =====
// One storage cell of the list: holds an entry and trades data with its neighbors.
`default_nettype none

module iiel_cell #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire iiel_pkg::cell_op_e    op_i,
  input  wire logic                  rd_sel_i,
  input  wire logic [WORD_WIDTH-1:0] word_i,
  input  wire logic [WORD_WIDTH-1:0] lower_i,
  input  wire logic [WORD_WIDTH-1:0] upper_i,
  output logic      [WORD_WIDTH-1:0] data_o,
  output logic      [WORD_WIDTH-1:0] tap_o
);

  logic [WORD_WIDTH-1:0] data_q;
  logic [WORD_WIDTH-1:0] data_d;

  always_comb begin
    case (op_i)
      iiel_pkg::CELL_LOAD:       data_d = word_i;
      iiel_pkg::CELL_FROM_LOWER: data_d = lower_i;
      iiel_pkg::CELL_FROM_UPPER: data_d = upper_i;
      default:                   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the selected cell drives its entry onto the read bus.
  assign tap_o  = rd_sel_i ? data_q : '0;

endmodule

`default_nettype wire

// ===== design/iiel_ctrl.sv =====
// Operation decoder: checks bounds and issues a command to every cell.
`default_nettype none

module iiel_ctrl #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic            valid_i,
  input  wire logic [2:0]      action_i,
  input  wire logic [CW-1:0]   position_i,
  input  wire logic [CW-1:0]   used_i,
  output iiel_pkg::cell_op_e   cell_op_o [CAPACITY],
  output logic [CAPACITY-1:0]  rd_sel_o,
  output iiel_pkg::ctrl_res_t  res_o
);

  logic full;
  logic empty;
  logic pos_gt_used;
  logic pos_ge_used;

  assign full        = (used_i == CW'(CAPACITY));
  assign empty       = (used_i == '0);
  assign pos_gt_used = (position_i > used_i);
  assign pos_ge_used = (position_i >= used_i);

  always_comb begin
    res_o    = '0;
    rd_sel_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op_o[i] = iiel_pkg::CELL_HOLD;
    end

    case (action_i)
      iiel_pkg::ACT_APPEND: begin
        if (full) begin
          res_o.status = iiel_pkg::ST_FULL;
        end else begin
          res_o.inc = valid_i;
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_i && CW'(i) == used_i) cell_op_o[i] = iiel_pkg::CELL_LOAD;
          end
        end
      end
      iiel_pkg::ACT_POP: begin
        if (empty) res_o.status = iiel_pkg::ST_EMPTY;
        else res_o.dec = valid_i;
      end
      iiel_pkg::ACT_INSERT: begin
        // The range check takes precedence over the full check.
        if (pos_gt_used) begin
          res_o.status = iiel_pkg::ST_RANGE;
        end else if (full) begin
          res_o.status = iiel_pkg::ST_FULL;
        end else begin
          res_o.inc = valid_i;
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_i && CW'(i) == position_i) begin
              cell_op_o[i] = iiel_pkg::CELL_LOAD;
            end else if (valid_i && CW'(i) > position_i) begin
              cell_op_o[i] = iiel_pkg::CELL_FROM_LOWER;
            end
          end
        end
      end
      iiel_pkg::ACT_ERASE: begin
        if (pos_ge_used) begin
          res_o.status = iiel_pkg::ST_RANGE;
        end else begin
          res_o.dec = valid_i;
          for (int i = 0; i < CAPACITY; i++) begin
            if (valid_i && CW'(i) >= position_i) cell_op_o[i] = iiel_pkg::CELL_FROM_UPPER;
          end
        end
      end
      iiel_pkg::ACT_READ: begin
        if (pos_ge_used) begin
          res_o.status = iiel_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            rd_sel_o[i] = (CW'(i) == position_i);
          end
        end
      end
      iiel_pkg::ACT_CLEAR: begin
        res_o.clr = valid_i;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/indexed_insert_erase_list.sv =====
// Top level of the indexed insert/erase list built as a row of storage cells.
//
// The block keeps an ordered list of up to CAPACITY words, one word in each
// cell of a row. A transaction is accepted at every rising edge with start_i
// high and busy_o low; busy_o never rises, so one operation can be accepted
// in every cycle. Each operation (append, remove tail, insert at an index,
// erase at an index, read at an index, clear) completes in the cycle it is accepted:
// all cells move in parallel, each taking its own word, the word of its lower
// or upper neighbor, or the incoming word. The result of the transaction
// appears on the cycle after acceptance, marked by done_o for exactly one
// cycle, and must be taken then because the receiver cannot stall the block.
// word_out_o carries the entry of a successful read and is zero otherwise;
// status_o reports ok, index out of range, list empty or list full; count_o
// holds the number of entries after the operation. A rejected operation
// leaves the list unchanged. Entries are not cleared at reset; only entries
// below the count are ever read, and they have always been written.

`default_nettype none

module indexed_insert_erase_list #(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [2:0]            action_i,
  input  wire logic [CW-1:0]         position_i,
  input  wire logic [WORD_WIDTH-1:0] word_in_i,
  output logic                       done_o,
  output logic      [WORD_WIDTH-1:0] word_out_o,
  output logic      [1:0]            status_o,
  output logic      [CW-1:0]         count_o
);

  logic                   accept;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          count_d;
  logic                   done_q;
  logic [WORD_WIDTH-1:0]  word_q;
  logic [1:0]             status_q;
  logic [WORD_WIDTH-1:0]  rd_word;
  logic [CAPACITY-1:0]    rd_sel;
  logic [WORD_WIDTH-1:0]  cell_data [CAPACITY];
  logic [WORD_WIDTH-1:0]  cell_tap  [CAPACITY];
  iiel_pkg::cell_op_e     cell_op   [CAPACITY];
  iiel_pkg::ctrl_res_t    res;

  // Every operation finishes in the cycle it is accepted.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  iiel_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .valid_i    (accept),
    .action_i   (action_i),
    .position_i (position_i),
    .used_i     (count_q),
    .cell_op_o  (cell_op),
    .rd_sel_o   (rd_sel),
    .res_o      (res)
  );

  // The row of cells. The ends of the row see zero from outside; those
  // inputs are only taken by cells that hold no live entry afterwards.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower;
    logic [WORD_WIDTH-1:0] upper;

    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end

    iiel_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op[g]),
      .rd_sel_i (rd_sel[g]),
      .word_i   (word_in_i),
      .lower_i  (lower),
      .upper_i  (upper),
      .data_o   (cell_data[g]),
      .tap_o    (cell_tap[g])
    );
  end

  // At most one cell drives a nonzero tap, so an OR collects the read word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  always_comb begin
    if (res.clr) begin
      count_d = '0;
    end else if (res.inc) begin
      count_d = count_q + CW'(1);
    end else if (res.dec) begin
      count_d = count_q - CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q   <= rd_word;
      status_q <= res.status;
    end
  end

  assign done_o     = done_q;
  assign word_out_o = word_q;
  assign status_o   = status_q;
  assign count_o    = count_q;

endmodule

`default_nettype wire

// ===== design/iiel_checker.sv =====
// Port-level checker for the indexed insert/erase list and its bind.
`default_nettype none

`include "indexed_insert_erase_list_defines.svh"

module iiel_checker #(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire logic                  done_o,
  input wire logic [WORD_WIDTH-1:0] word_out_o,
  input wire logic [1:0]            status_o,
  input wire logic [CW-1:0]         count_o
);

  // Each accepted transaction yields its result in the next cycle.
  `IIEL_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, start_i && !busy_o, done_o, "missing result")
  // No result appears without a transaction before it.
  `IIEL_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !(start_i && !busy_o), !done_o, "spurious result")
  // A rejected operation leaves the count unchanged.
  `IIEL_ASSERT_SAME(a_reject_count, clk_i, rst_ni, done_o && status_o != iiel_pkg::ST_OK, $stable(count_o), "rejected op changed count")
  // A rejected operation returns no data.
  `IIEL_ASSERT_SAME(a_reject_word, clk_i, rst_ni, done_o && status_o != iiel_pkg::ST_OK, word_out_o == '0, "rejected op returned data")
  // The count never exceeds the capacity.
  `IIEL_ASSERT_SAME(a_count_max, clk_i, rst_ni, done_o, count_o <= CW'(CAPACITY), "count above capacity")

endmodule

bind indexed_insert_erase_list iiel_checker #(
  .CAPACITY   (CAPACITY),
  .WORD_WIDTH (WORD_WIDTH)
) u_iiel_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .word_out_o (word_out_o),
  .status_o   (status_o),
  .count_o    (count_o)
);

`default_nettype wire
